// ===== rtl/ual_pkg.sv =====
// Shared constants for the unordered array list: field widths, operation
// and status codes, and the default store depth.
// No dependencies.
package ual_pkg;

  localparam int unsigned DEPTH_DEF   = 64;
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned POS_W       = 7;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_DUMP   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

endpackage

// ===== rtl/ual_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ual_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/unordered_array_list.sv =====
// Unordered array list: sequencer, element count and result registers.
// Depends on ual_pkg and ual_ram.
//
// Usage: drive operation_i and value_i with start_i high; the item is taken
// at a rising edge where busy_o is low. Every result appears for exactly one
// cycle with result_valid_o high; last_o marks the final result of the item.
// The receiver cannot hold results off.
// Sequencing, set by the single RAM read port walking the store
// one entry per cycle:
//   insert, or any operation on an empty list: result next cycle.
//   search: entries are read from position 1 until a hit or the last entry.
//   delete: as search, then the later entries are moved down one place.
//   dump: n = min(count, 64) results, one per cycle.
// busy_o is high while the store is being walked; a new item may be started
// in the cycle the final result is shown.
// Reset empties the list (count to zero); store contents are left as they
// are and are never read before written.
module unordered_array_list #(
  parameter int unsigned DEPTH = ual_pkg::DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          operation_i,
  input  logic signed [ual_pkg::DATA_W-1:0]   value_i,
  output logic                                result_valid_o,
  output logic [1:0]                          status_o,
  output logic [ual_pkg::POS_W-1:0]           position_o,
  output logic signed [ual_pkg::DATA_W-1:0]   data_o,
  output logic                                last_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = (CW + 1 > 8) ? CW + 1 : 8;
  localparam int unsigned DW = ual_pkg::DATA_W;
  localparam int unsigned PW = ual_pkg::POS_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DUMP  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [1:0]    op_q, op_d;
  logic [DW-1:0] value_q, value_d;
  logic [PW-1:0] hit_q, hit_d;

  logic          res_vld_q, res_vld_d;
  logic [1:0]    status_q, status_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [DW-1:0] data_q, data_d;
  logic          last_q, last_d;

  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data;

  logic [LW-1:0] cnt_l, idx1_l, idx2_l, dump_n_l;

  ual_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign cnt_l    = LW'(count_q);
  assign idx1_l   = LW'(idx_q) + LW'(1);
  assign idx2_l   = LW'(idx_q) + LW'(2);
  assign dump_n_l = (cnt_l > LW'(ual_pkg::MAX_RESULTS)) ? LW'(ual_pkg::MAX_RESULTS) : cnt_l;

  // rd_addr is the entry whose data is on rd_data in the following cycle
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    op_d      = op_q;
    value_d   = value_q;
    hit_d     = hit_q;
    res_vld_d = 1'b0;
    status_d  = status_q;
    pos_d     = pos_q;
    data_d    = data_q;
    last_d    = last_q;
    we        = 1'b0;
    waddr     = count_q[AW-1:0];
    wdata     = value_i;
    rd_addr   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d    = operation_i;
          value_d = value_i;
          idx_d   = '0;
          unique case (operation_i)
            ual_pkg::OP_INSERT: begin
              res_vld_d = 1'b1;
              data_d    = value_i;
              last_d    = 1'b1;
              if (cnt_l >= LW'(DEPTH)) begin
                status_d = ual_pkg::ST_FULL;
                pos_d    = '0;
              end else begin
                we       = 1'b1;
                count_d  = count_q + CW'(1);
                status_d = ual_pkg::ST_OK;
                pos_d    = PW'(cnt_l + LW'(1));
              end
            end
            ual_pkg::OP_DELETE, ual_pkg::OP_SEARCH: begin
              if (count_q == '0) begin
                res_vld_d = 1'b1;
                status_d  = ual_pkg::ST_EMPTY;
                pos_d     = '0;
                data_d    = value_i;
                last_d    = 1'b1;
              end else begin
                state_d = S_SCAN;
              end
            end
            ual_pkg::OP_DUMP: begin
              if (count_q == '0) begin
                res_vld_d = 1'b1;
                status_d  = ual_pkg::ST_EMPTY;
                pos_d     = '0;
                data_d    = '0;
                last_d    = 1'b1;
              end else begin
                state_d = S_DUMP;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rd_data == value_q) begin
          if (op_q == ual_pkg::OP_SEARCH || idx1_l >= cnt_l) begin
            // search hit, or delete of the final entry: nothing to move
            if (op_q != ual_pkg::OP_SEARCH) begin
              count_d = count_q - CW'(1);
            end
            res_vld_d = 1'b1;
            status_d  = ual_pkg::ST_OK;
            pos_d     = PW'(idx1_l);
            data_d    = value_q;
            last_d    = 1'b1;
            state_d   = S_IDLE;
          end else begin
            hit_d   = PW'(idx1_l);
            rd_addr = AW'(idx1_l);
            state_d = S_SHIFT;
          end
        end else if (idx1_l >= cnt_l) begin
          res_vld_d = 1'b1;
          status_d  = ual_pkg::ST_NOTFOUND;
          pos_d     = '0;
          data_d    = value_q;
          last_d    = 1'b1;
          state_d   = S_IDLE;
        end else begin
          idx_d   = AW'(idx1_l);
          rd_addr = AW'(idx1_l);
        end
      end

      S_SHIFT: begin
        // rd_data holds entry idx+1; move it down
        we    = 1'b1;
        waddr = idx_q;
        wdata = rd_data;
        if (idx2_l >= cnt_l) begin
          count_d   = count_q - CW'(1);
          res_vld_d = 1'b1;
          status_d  = ual_pkg::ST_OK;
          pos_d     = hit_q;
          data_d    = value_q;
          last_d    = 1'b1;
          state_d   = S_IDLE;
        end else begin
          idx_d   = AW'(idx1_l);
          rd_addr = AW'(idx2_l);
        end
      end

      S_DUMP: begin
        res_vld_d = 1'b1;
        status_d  = ual_pkg::ST_OK;
        pos_d     = PW'(idx1_l);
        data_d    = rd_data;
        last_d    = (idx1_l == dump_n_l);
        if (idx1_l == dump_n_l) begin
          state_d = S_IDLE;
        end else begin
          idx_d   = AW'(idx1_l);
          rd_addr = AW'(idx1_l);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    value_q  <= value_d;
    hit_q    <= hit_d;
    status_q <= status_d;
    pos_q    <= pos_d;
    data_q   <= data_d;
    last_q   <= last_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = res_vld_q;
  assign status_o       = status_q;
  assign position_o     = pos_q;
  assign data_o         = $signed(data_q);
  assign last_o         = last_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW'(count_q) <= LW'(DEPTH))
    else $error("element count above store depth");

  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> !busy_o)
    else $error("final result shown while still busy");

  a_mid_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy_o)
    else $error("non-final result shown while idle");

  a_insert_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && operation_i == ual_pkg::OP_INSERT |=> result_valid_o && last_o)
    else $error("insert gave no result in the next cycle");

  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == ual_pkg::ST_FULL |-> LW'(count_q) == LW'(DEPTH))
    else $error("full reported below depth");

endmodule
